// ===== rtl/ideq_pkg.sv =====
package ideq_pkg;

    localparam int NUM_INPUTS = 4;
    localparam int RING_DEPTH = 16;
    localparam int PIN_W      = 4;
    localparam int CODE_W     = 8;
    localparam int TICK_W     = 8;
    localparam int PENDING_W  = 4;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [TICK_W-1:0] ON_TICKS_RESET  = 8'd3;
    localparam logic [TICK_W-1:0] OFF_TICKS_RESET = 8'd3;
    localparam logic [DATA_W-1:0] ON_CODES_RESET  = 32'h0403_0201;
    localparam logic [DATA_W-1:0] OFF_CODES_RESET = 32'h0807_0605;

    typedef enum logic
    {
        OP_SCAN = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REG_ON_TICKS  = 2'd0,
        REG_OFF_TICKS = 2'd1,
        REG_ON_CODES  = 2'd2,
        REG_OFF_CODES = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        logic              push;
        logic [CODE_W-1:0] code;
    } push_t;

    typedef struct packed
    {
        logic [CODE_W-1:0]    code;
        logic                 valid;
        logic [PENDING_W-1:0] pending;
    } result_t;

endpackage

// ===== rtl/ideq_lane.sv =====
module ideq_lane
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           scan,
    input  logic                           pin_high,
    input  logic [ideq_pkg::TICK_W-1:0]    on_ticks,
    input  logic [ideq_pkg::TICK_W-1:0]    off_ticks,
    input  logic [ideq_pkg::CODE_W-1:0]    on_code,
    input  logic [ideq_pkg::CODE_W-1:0]    off_code,
    output ideq_pkg::push_t                result
);
    import ideq_pkg::*;

    logic [TICK_W-1:0] active_reg;
    logic [TICK_W-1:0] active_next;
    logic [TICK_W-1:0] inactive_reg;
    logic [TICK_W-1:0] inactive_next;

    always_comb
    begin
        active_next   = active_reg;
        inactive_next = inactive_reg;
        result        = '0;
        if (scan)
        begin
            if (pin_high)
            begin
                if (inactive_reg < off_ticks)
                begin
                    inactive_next = TICK_W'(inactive_reg + 1'b1);
                    if (inactive_next == off_ticks)
                    begin
                        active_next = '0;
                        result.push = 1'b1;
                        result.code = off_code;
                    end
                end
                else
                begin
                    active_next = '0;
                end
            end
            else
            begin
                if (active_reg < on_ticks)
                begin
                    active_next = TICK_W'(active_reg + 1'b1);
                    if (active_next == on_ticks)
                    begin
                        inactive_next = '0;
                        result.push   = 1'b1;
                        result.code   = on_code;
                    end
                end
                else
                begin
                    inactive_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            inactive_reg <= '0;
        end
        else
        begin
            active_reg   <= active_next;
            inactive_reg <= inactive_next;
        end
    end

endmodule

// ===== rtl/ideq_ring.sv =====
module ideq_ring
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ideq_pkg::push_t             pushes [ideq_pkg::NUM_INPUTS],
    input  logic                        pop,
    output logic [ideq_pkg::CODE_W-1:0] pop_code,
    output logic                        pop_valid,
    output logic [ideq_pkg::IDX_W-1:0]  pending
);
    import ideq_pkg::*;

    logic [CODE_W-1:0] ring_reg [RING_DEPTH];
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [IDX_W-1:0]  wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [IDX_W-1:0]  slot [NUM_INPUTS+1];
    logic              wen [RING_DEPTH];
    logic [CODE_W-1:0] wdata [RING_DEPTH];
    logic [IDX_W:0]    pend_wide;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    // each pushing lane takes the slot after the previous pusher, in lane order
    always_comb
    begin
        slot[0] = wr_idx_reg;
        for (int i = 0; i < NUM_INPUTS; i++)
        begin
            slot[i+1] = pushes[i].push ? ring_next(slot[i]) : slot[i];
        end
        wr_idx_next = slot[NUM_INPUTS];
    end

    // later lanes win where a slot is written twice
    always_comb
    begin
        for (int j = 0; j < RING_DEPTH; j++)
        begin
            wen[j]   = 1'b0;
            wdata[j] = '0;
            for (int i = 0; i < NUM_INPUTS; i++)
            begin
                if (pushes[i].push && slot[i] == IDX_W'(j))
                begin
                    wen[j]   = 1'b1;
                    wdata[j] = pushes[i].code;
                end
            end
        end
    end

    always_comb
    begin
        pop_valid   = pop && (rd_idx_reg != wr_idx_reg);
        pop_code    = pop_valid ? ring_reg[rd_idx_reg] : '0;
        rd_idx_next = pop_valid ? ring_next(rd_idx_reg) : rd_idx_reg;
        if (wr_idx_next >= rd_idx_next)
        begin
            pend_wide = {1'b0, wr_idx_next} - {1'b0, rd_idx_next};
        end
        else
        begin
            pend_wide = {1'b0, wr_idx_next} + (IDX_W+1)'(RING_DEPTH) - {1'b0, rd_idx_next};
        end
        pending = pend_wide[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < RING_DEPTH; j++)
        begin
            if (wen[j])
            begin
                ring_reg[j] <= wdata[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

endmodule

// ===== rtl/input_debounce_event_queue_core.sv =====
// Debounced event queue for four active-low inputs.
// Input channel (item_valid / item_stall) carries operation and pin_levels.
// A scan item advances the per-input on/off debounce counters, one lane per
// input, and queues the on or off code of every input whose counter reaches
// its threshold, in input order, into a 16-entry ring. A read item pops the
// oldest code; an empty ring gives event_code 0 and event_valid 0.
// Output channel (result_valid / result_stall) returns one result per item:
// event_code, event_valid and pending (entries queued after the item).
// The result is registered in the output buffer; one item is taken every
// cycle while item_stall is low.
// A two-entry output buffer (result register plus skid register) means the
// block keeps taking items while a result waits; item_stall rises only
// once the skid register is full, and drops when the receiver takes one.
// Thresholds and codes are written through the APB port; the user must write them only while idle (not enforced).
// Reset clears counters, ring indices and buffers and loads the default
// thresholds (3) and codes; ring contents are not cleared.
module input_debounce_event_queue_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic                             operation,
    input  logic [ideq_pkg::PIN_W-1:0]       pin_levels,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [ideq_pkg::CODE_W-1:0]      event_code,
    output logic                             event_valid,
    output logic [ideq_pkg::PENDING_W-1:0]   pending,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ideq_pkg::ADDR_W-1:0]      paddr,
    input  logic [ideq_pkg::DATA_W-1:0]      pwdata,
    output logic [ideq_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import ideq_pkg::*;

    logic [TICK_W-1:0] on_ticks_reg;
    logic [TICK_W-1:0] off_ticks_reg;
    logic [DATA_W-1:0] on_codes_reg;
    logic [DATA_W-1:0] off_codes_reg;
    reg_idx_t          reg_sel;
    logic              cfg_write;

    logic              accept;
    logic              scan;
    logic              pop;
    push_t             pushes [NUM_INPUTS];
    logic [CODE_W-1:0] pop_code;
    logic              pop_valid;
    logic [IDX_W-1:0]  ring_pending;
    logic [IDX_W+PENDING_W-1:0] pend_pad;
    result_t           result;

    result_t           out_reg;
    logic              out_valid_reg;
    result_t           skid_reg;
    logic              skid_valid_reg;
    logic              out_take;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            REG_ON_TICKS:  prdata = {{(DATA_W-TICK_W){1'b0}}, on_ticks_reg};
            REG_OFF_TICKS: prdata = {{(DATA_W-TICK_W){1'b0}}, off_ticks_reg};
            REG_ON_CODES:  prdata = on_codes_reg;
            REG_OFF_CODES: prdata = off_codes_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_ticks_reg  <= ON_TICKS_RESET;
            off_ticks_reg <= OFF_TICKS_RESET;
            on_codes_reg  <= ON_CODES_RESET;
            off_codes_reg <= OFF_CODES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_ON_TICKS:  on_ticks_reg  <= pwdata[TICK_W-1:0];
                REG_OFF_TICKS: off_ticks_reg <= pwdata[TICK_W-1:0];
                REG_ON_CODES:  on_codes_reg  <= pwdata;
                REG_OFF_CODES: off_codes_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // item handling
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && !skid_valid_reg;
    assign scan       = accept && (op_t'(operation) == OP_SCAN);
    assign pop        = accept && (op_t'(operation) == OP_READ);

    // one debounce lane per input, pins past the field read as active
    for (genvar i = 0; i < NUM_INPUTS; i++)
    begin : g_lane
        logic pin_high;
        if (i < PIN_W)
        begin : g_pin
            assign pin_high = pin_levels[i];
        end
        else
        begin : g_nopin
            assign pin_high = 1'b0;
        end

        ideq_lane u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .scan      (scan),
            .pin_high  (pin_high),
            .on_ticks  (on_ticks_reg),
            .off_ticks (off_ticks_reg),
            .on_code   (on_codes_reg[CODE_W*(i%4) +: CODE_W]),
            .off_code  (off_codes_reg[CODE_W*(i%4) +: CODE_W]),
            .result    (pushes[i])
        );
    end

    ideq_ring u_ring
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pushes    (pushes),
        .pop       (pop),
        .pop_code  (pop_code),
        .pop_valid (pop_valid),
        .pending   (ring_pending)
    );

    assign pend_pad       = {{PENDING_W{1'b0}}, ring_pending};
    assign result.code    = pop_code;
    assign result.valid   = pop_valid;
    assign result.pending = pend_pad[PENDING_W-1:0];

    // output register with skid stage
    assign out_take = out_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign event_code   = out_reg.code;
    assign event_valid  = out_reg.valid;
    assign pending      = out_reg.pending;

endmodule
